// File: src/djbks_pkg.sv
// Package for the djb2-keyed xorshift stream cipher: commands, beat types, constants.
`default_nettype none

package djbks_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_KEY   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_e;

  localparam int unsigned CmdWidth  = 2;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned StateWidth = 64;

  localparam logic [StateWidth-1:0] HashInit = 64'd5381;
  localparam logic [StateWidth-1:0] ZeroSeed = 64'h0000_0000_FFFF_FFFF;

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 7;
  localparam int unsigned ShiftC = 17;

  typedef struct packed {
    logic [CmdWidth-1:0]  command;
    logic [ByteWidth-1:0] byte_value;
  } item_t;

endpackage

`default_nettype wire

// File: src/djbks_if.sv
// Valid/ready channel interfaces for the cipher input and output beats.
`default_nettype none

interface djbks_in_if;
  import djbks_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CmdWidth-1:0]  command;
  logic [ByteWidth-1:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface djbks_out_if;
  import djbks_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// File: src/djb2_keyed_xorshift_stream_cipher.sv
// Pipeline: an input register holds each accepted beat; a data beat's result then goes to
//   an output register; the hash add or xorshift step lies between the two registers.
// Throughput: one beat per cycle unless a data beat stalls on a full output register;
//   clear/key beats give no output beat.
// Reset: rst_ni is asynchronous, active low; key hash goes to 5381, keystream to zero
//   and unseeded, both pipeline registers empty. No clearing pass is needed.
// Top level of the djb2-keyed xorshift64 byte stream cipher.
`default_nettype none

module djb2_keyed_xorshift_stream_cipher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  djbks_in_if.sink  in_i,
  djbks_out_if.source out_o
);
  import djbks_pkg::*;

  // Input register: holds one accepted beat until the core can take it.
  logic  s1_valid_q, s1_valid_d;
  item_t s1_item_q;

  // Output register: one pending result byte.
  logic                 out_valid_q, out_valid_d;
  logic [ByteWidth-1:0] out_data_q;

  logic                 s1_is_data;
  logic                 advance;
  logic                 in_fire;
  logic [ByteWidth-1:0] ks_byte;

  assign s1_is_data = (s1_item_q.command == CMD_DATA);

  // A data beat needs a free (or draining) output slot; other beats always move.
  assign advance  = s1_valid_q && (!s1_is_data || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && s1_is_data) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.command    <= in_i.command;
      s1_item_q.byte_value <= in_i.byte_value;
    end
    if (advance && s1_is_data) begin
      out_data_q <= s1_item_q.byte_value ^ ks_byte;
    end
  end

  djbks_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (s1_item_q),
    .ks_byte_o (ks_byte)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_data_q))
    else $error("pending output beat was overwritten or dropped");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled input register changed");

  a_data_makes_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_is_data |=> out_valid_q)
    else $error("processed data beat gave no output beat");
`endif

endmodule

`default_nettype wire

// File: src/djbks_core.sv
// Key hash, keystream state and the one-step update for each processed beat.
`default_nettype none

module djbks_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_en_i,
  input  wire djbks_pkg::item_t          item_i,
  output logic [djbks_pkg::ByteWidth-1:0] ks_byte_o
);
  import djbks_pkg::*;

  logic [StateWidth-1:0] hash_q, hash_d;
  logic [StateWidth-1:0] ks_q, ks_d;
  logic                  seeded_q, seeded_d;

  logic [StateWidth-1:0] seed;
  logic [StateWidth-1:0] x0, x1, x2, x3;

  // hash_q (or ZeroSeed) seeds only the first data beat after a clear or reset
  assign seed = seeded_q ? ks_q : ((hash_q != '0) ? hash_q : ZeroSeed);
  assign x0 = seed;
  assign x1 = x0 ^ (x0 << ShiftA);
  assign x2 = x1 ^ (x1 >> ShiftB);
  assign x3 = x2 ^ (x2 << ShiftC);

  assign ks_byte_o = x3[ByteWidth-1:0];

  always_comb begin
    hash_d   = hash_q;
    ks_d     = ks_q;
    seeded_d = seeded_q;
    if (step_en_i) begin
      case (cmd_e'(item_i.command))
        CMD_CLEAR: begin
          hash_d   = HashInit;
          ks_d     = '0;
          seeded_d = 1'b0;
        end
        CMD_KEY: begin
          // hash*33 + byte, wraps mod 2^64
          hash_d = (hash_q << 5) + hash_q
                 + {{(StateWidth-ByteWidth){1'b0}}, item_i.byte_value};
        end
        CMD_DATA: begin
          ks_d     = x3;
          seeded_d = 1'b1;
        end
        default: begin
          // unused code: no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= HashInit;
      ks_q     <= '0;
      seeded_q <= 1'b0;
    end else begin
      hash_q   <= hash_d;
      ks_q     <= ks_d;
      seeded_q <= seeded_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.command == CMD_CLEAR |=>
      !seeded_q && hash_q == HashInit && ks_q == '0)
    else $error("clear did not restart key hash and keystream");

  a_data_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.command == CMD_DATA |=> seeded_q)
    else $error("data beat left keystream unseeded");

  a_ks_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |-> ks_q != '0)
    else $error("seeded keystream reached all zeros");

  a_key_keeps_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && item_i.command != CMD_DATA && item_i.command != CMD_CLEAR |=>
      $stable(ks_q) && $stable(seeded_q))
    else $error("non-data beat disturbed keystream");
`endif

endmodule

`default_nettype wire
